@@ rtl/core/osg_pkg.sv @@
`default_nettype none

package osg_pkg;

    // Spreading length of one data bit.
    localparam int CHIPS_PER_BIT = 128;
    localparam int CIB_W = (CHIPS_PER_BIT > 1) ? $clog2(CHIPS_PER_BIT) : 1;

    // Fixed-point widths and constants.
    localparam int SPC_W   = 24;  // samples per chip, Q8.16
    localparam int RECIP_W = 25;  // reciprocal, Q0.24
    localparam int SAMP_W  = 16;  // output sample, Q1.14
    localparam int CNT_W   = 8;   // sample counter within a chip
    localparam int FRAC_W  = 16;  // rate accumulator fraction
    localparam int PROD_W  = CNT_W + RECIP_W;

    localparam logic [RECIP_W-1:0] ONE_Q24  = RECIP_W'(25'h1000000);
    localparam logic [RECIP_W-1:0] HALF_Q24 = RECIP_W'(25'h0800000);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_CHIP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHIP_RECIPROCAL  = 1'b1;

    // Chip levels are -1, 0 or +1.
    localparam logic signed [1:0] LEVEL_POS  = 2'sb01;
    localparam logic signed [1:0] LEVEL_NEG  = 2'sb11;
    localparam logic signed [1:0] LEVEL_ZERO = 2'sb00;

    // Per-sample chip context handed from the chip controller to the interpolator.
    typedef struct packed {
        logic [CNT_W-1:0]  sample_pos;
        logic signed [1:0] last_i;
        logic signed [1:0] last_q;
        logic signed [1:0] cur_i;
        logic signed [1:0] cur_q;
    } t_chip_info;

    // Spread one chip by the data bit: equal bits give +1, different bits give -1.
    function automatic logic signed [1:0] osg_spread(input logic chip, input logic dbit);
        return (chip ^ dbit) ? LEVEL_NEG : LEVEL_POS;
    endfunction

    // level * 16384 + round(delta * f), rounding half away from zero; f is Q0.24.
    function automatic logic signed [17:0] osg_ramp(
        input logic signed [1:0]   level,
        input logic signed [2:0]   delta,
        input logic [RECIP_W-1:0]  f
    );
        logic [1:0]          mag_d;
        logic [RECIP_W:0]    mag;
        logic [RECIP_W:0]    rnd;
        logic [15:0]         r;
        logic signed [17:0]  base;
        mag_d = delta[2] ? 2'(-delta) : delta[1:0];
        case (mag_d)
            2'd1:    mag = {1'b0, f};
            2'd2:    mag = {f, 1'b0};
            default: mag = '0;
        endcase
        rnd  = mag + (RECIP_W+1)'(512);
        r    = rnd[RECIP_W:10];
        base = {{2{level[1]}}, level, 14'd0};
        return delta[2] ? base - $signed({2'b00, r}) : base + $signed({2'b00, r});
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/osg_chip_ctrl.sv @@
`default_nettype none

module osg_chip_ctrl
    import osg_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire logic             i_start_frame,
    input  wire logic             i_data_bit,
    input  wire logic             i_i_chip,
    input  wire logic             i_q_chip,
    input  wire logic [SPC_W-1:0] i_samples_per_chip,
    output t_chip_info            o_info,
    output logic                  o_chip_done,
    output logic                  o_bit_done
);

    logic [CNT_W-1:0]  r_sample_in_chip, n_sample_in_chip;
    logic [CNT_W-1:0]  r_samples_this_chip, n_samples_this_chip;
    logic [FRAC_W-1:0] r_rate_fraction, n_rate_fraction;
    logic [CIB_W-1:0]  r_chip_in_bit, n_chip_in_bit;
    logic signed [1:0] r_last_i, n_last_i;
    logic signed [1:0] r_last_q, n_last_q;

    // Chip bookkeeping: frame start wins, then the count of samples for a new chip,
    // then the advance to the next sample or chip.
    always_comb begin
        logic [CNT_W-1:0]      sic;
        logic [CIB_W-1:0]      cib;
        logic [FRAC_W-1:0]     frac;
        logic [SPC_W:0]        acc;
        logic [SPC_W-FRAC_W:0] cnt;
        logic [CNT_W-1:0]      stc;
        logic [CNT_W:0]        sic_inc;
        logic [CIB_W:0]        cib_inc;
        logic signed [1:0]     lvl_i;
        logic signed [1:0]     lvl_q;
        logic signed [1:0]     cur_i;
        logic signed [1:0]     cur_q;

        sic   = i_start_frame ? '0 : r_sample_in_chip;
        cib   = i_start_frame ? '0 : r_chip_in_bit;
        frac  = (i_start_frame || cib == '0) ? '0 : r_rate_fraction;
        lvl_i = i_start_frame ? LEVEL_ZERO : r_last_i;
        lvl_q = i_start_frame ? LEVEL_ZERO : r_last_q;
        cur_i = osg_spread(i_i_chip, i_data_bit);
        cur_q = osg_spread(i_q_chip, i_data_bit);

        // Sample count of a new chip from the fractional rate accumulator.
        acc = (SPC_W+1)'(frac) + (SPC_W+1)'(i_samples_per_chip);
        cnt = acc[SPC_W:FRAC_W];
        if (cnt > (SPC_W-FRAC_W+1)'(255)) begin
            stc = 8'd255;
        end else if (cnt == '0) begin
            stc = 8'd1;
        end else begin
            stc = cnt[CNT_W-1:0];
        end

        n_rate_fraction     = r_rate_fraction;
        n_samples_this_chip = r_samples_this_chip;
        if (sic == '0) begin
            n_rate_fraction     = acc[FRAC_W-1:0];
            n_samples_this_chip = stc;
        end else begin
            stc = r_samples_this_chip;
        end

        sic_inc     = {1'b0, sic} + (CNT_W+1)'(1);
        cib_inc     = {1'b0, cib} + (CIB_W+1)'(1);
        o_chip_done = (sic_inc >= {1'b0, stc});
        o_bit_done  = 1'b0;

        n_last_i         = lvl_i;
        n_last_q         = lvl_q;
        n_chip_in_bit    = cib;
        n_sample_in_chip = sic_inc[CNT_W-1:0];
        if (o_chip_done) begin
            n_last_i         = cur_i;
            n_last_q         = cur_q;
            n_sample_in_chip = '0;
            if (cib_inc >= (CIB_W+1)'(CHIPS_PER_BIT)) begin
                n_chip_in_bit = '0;
                o_bit_done    = 1'b1;
            end else begin
                n_chip_in_bit = cib_inc[CIB_W-1:0];
            end
        end

        o_info.sample_pos = sic;
        o_info.last_i     = lvl_i;
        o_info.last_q     = lvl_q;
        o_info.cur_i      = cur_i;
        o_info.cur_q      = cur_q;
    end

    // State advances only when a sample is produced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_in_chip    <= '0;
            r_samples_this_chip <= '0;
            r_rate_fraction     <= '0;
            r_chip_in_bit       <= '0;
            r_last_i            <= LEVEL_ZERO;
            r_last_q            <= LEVEL_ZERO;
        end else if (i_fire) begin
            r_sample_in_chip    <= n_sample_in_chip;
            r_samples_this_chip <= n_samples_this_chip;
            r_rate_fraction     <= n_rate_fraction;
            r_chip_in_bit       <= n_chip_in_bit;
            r_last_i            <= n_last_i;
            r_last_q            <= n_last_q;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/osg_interp.sv @@
`default_nettype none

module osg_interp
    import osg_pkg::*;
(
    input  wire t_chip_info            i_info,
    input  wire logic [RECIP_W-1:0]    i_chip_reciprocal,
    output logic signed [SAMP_W-1:0]   o_i_sample,
    output logic signed [SAMP_W-1:0]   o_q_sample
);

    logic [PROD_W-1:0]  prod;
    logic [RECIP_W-1:0] frac_pos;
    logic [RECIP_W-2:0] q_off;
    logic [RECIP_W-1:0] q_frac;
    logic signed [2:0]  delta_i;
    logic signed [2:0]  delta_q;
    logic signed [17:0] i_full;
    logic signed [17:0] q_full;

    // Position within the chip, limited to one full chip.
    assign prod     = PROD_W'(i_info.sample_pos) * PROD_W'(i_chip_reciprocal);
    assign frac_pos = (prod > PROD_W'(ONE_Q24)) ? ONE_Q24 : prod[RECIP_W-1:0];

    // Q runs on the second half of the chip at twice the slope.
    assign q_off  = (RECIP_W-1)'(frac_pos - HALF_Q24);
    assign q_frac = {q_off, 1'b0};

    assign delta_i = 3'(i_info.cur_i) - 3'(i_info.last_i);
    assign delta_q = 3'(i_info.cur_q) - 3'(i_info.last_q);

    // Linear interpolation from the previous chip level.
    always_comb begin
        i_full = osg_ramp(i_info.last_i, delta_i, frac_pos);
        if (frac_pos < HALF_Q24) begin
            q_full = {{2{i_info.last_q[1]}}, i_info.last_q, 14'd0};
        end else begin
            q_full = osg_ramp(i_info.last_q, delta_q, q_frac);
        end
    end

    assign o_i_sample = i_full[SAMP_W-1:0];
    assign o_q_sample = q_full[SAMP_W-1:0];

endmodule

`default_nettype wire

@@ rtl/core/oqpsk_dsss_sample_generator.sv @@
// OQPSK sample generator with DSSS spreading and linear chip interpolation. Each input
// transfer is one sample tick carrying the data bit and the I/Q chip pair, held by the
// source while stalled; each produces exactly one output transfer with the I and Q
// samples in Q1.14. A chip of bit 0 is inverted. I ramps linearly from the previous chip
// level; Q holds for half a chip and then ramps at twice the slope. The number of samples
// per chip comes from a Q8.16 rate accumulator that restarts at every bit, and
// chip_reciprocal must be set to one over samples_per_chip (Q0.24). start_frame clears
// the previous levels, counters and accumulator. Unless the output stalls, it takes one
// transfer per clock (input register, then result register), and the chip and bit
// counters close their loop in the result stage, one sample per cycle. Configuration
// writes are always ready and are to be made only while the block is idle.
`default_nettype none

module oqpsk_dsss_sample_generator
    import osg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write channel.
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [RECIP_W-1:0]    i_cfg_data,
    // Tick input channel.
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_start_frame,
    input  wire logic                  i_data_bit,
    input  wire logic                  i_i_chip,
    input  wire logic                  i_q_chip,
    // Sample output channel.
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic signed [SAMP_W-1:0]   o_i_sample,
    output logic signed [SAMP_W-1:0]   o_q_sample,
    output logic                       o_chip_done,
    output logic                       o_bit_done
);

    logic [SPC_W-1:0]   r_samples_per_chip;
    logic [RECIP_W-1:0] r_chip_reciprocal;

    logic r_in_valid;
    logic r_start_frame;
    logic r_data_bit;
    logic r_i_chip;
    logic r_q_chip;

    logic                     r_out_valid;
    logic signed [SAMP_W-1:0] r_i_sample;
    logic signed [SAMP_W-1:0] r_q_sample;
    logic                     r_chip_done;
    logic                     r_bit_done;

    logic                     out_free;
    logic                     in_load;
    logic                     fire;
    t_chip_info               info;
    logic                     chip_done;
    logic                     bit_done;
    logic signed [SAMP_W-1:0] i_sample;
    logic signed [SAMP_W-1:0] q_sample;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples_per_chip <= SPC_W'(24'd4266394);
            r_chip_reciprocal  <= RECIP_W'(25'd257715);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SAMPLES_PER_CHIP: r_samples_per_chip <= i_cfg_data[SPC_W-1:0];
                CFG_CHIP_RECIPROCAL:  r_chip_reciprocal  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline flow: the result register is free when empty or being taken.
    assign out_free = !r_out_valid || !i_stall;
    assign in_load  = out_free || !r_in_valid;
    assign fire     = out_free && r_in_valid;
    assign o_stall  = !in_load;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_start_frame <= i_start_frame;
            r_data_bit    <= i_data_bit;
            r_i_chip      <= i_i_chip;
            r_q_chip      <= i_q_chip;
        end
    end

    // Chip bookkeeping and interpolation.
    osg_chip_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_fire             (fire),
        .i_start_frame      (r_start_frame),
        .i_data_bit         (r_data_bit),
        .i_i_chip           (r_i_chip),
        .i_q_chip           (r_q_chip),
        .i_samples_per_chip (r_samples_per_chip),
        .o_info             (info),
        .o_chip_done        (chip_done),
        .o_bit_done         (bit_done)
    );

    osg_interp u_interp (
        .i_info            (info),
        .i_chip_reciprocal (r_chip_reciprocal),
        .o_i_sample        (i_sample),
        .o_q_sample        (q_sample)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_i_sample  <= i_sample;
            r_q_sample  <= q_sample;
            r_chip_done <= chip_done;
            r_bit_done  <= bit_done;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_i_sample  = r_i_sample;
    assign o_q_sample  = r_q_sample;
    assign o_chip_done = r_chip_done;
    assign o_bit_done  = r_bit_done;

endmodule

`default_nettype wire

@@ rtl/core/osg_checker.sv @@
`default_nettype none

module osg_checker
    import osg_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_valid,
    input wire logic                  o_stall,
    input wire logic                  o_valid,
    input wire logic                  i_stall,
    input wire logic signed [SAMP_W-1:0] o_i_sample,
    input wire logic signed [SAMP_W-1:0] o_q_sample,
    input wire logic                  o_chip_done,
    input wire logic                  o_bit_done
);

    // A pending result stays offered while the receiver stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_i_sample) && $stable(o_q_sample))
        else $error("output transfer dropped or changed while stalled");

    // The end of a bit is always the end of a chip.
    a_bit_in_chip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bit_done |-> o_chip_done)
        else $error("bit_done without chip_done");

    // Samples never leave the unit range.
    a_i_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_i_sample >= -16'sd16384 && o_i_sample <= 16'sd16384)
        else $error("I sample out of range");

    a_q_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_q_sample >= -16'sd16384 && o_q_sample <= 16'sd16384)
        else $error("Q sample out of range");

    // A result taken in a cycle with no input in flight behind it leaves the output empty.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall && !i_valid ##1 o_valid && !i_stall |=> !o_valid)
        else $error("output produced without an input transfer");

endmodule

bind oqpsk_dsss_sample_generator osg_checker u_osg_checker (.*);

`default_nettype wire
